// ----- hdl/tlb_pkg.sv -----
// Shared types, widths and codes for the recency-ordered translation buffer.
// Used by tlb_match and tlb_mru_lookup_insert_invalidate.
package tlb_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int KEY_W   = 64;
  localparam int PA_W    = 48;
  localparam int BB_W    = 6;
  localparam int ATTR_W  = 13;
  localparam int ENTRY_W = PA_W + BB_W + ATTR_W;

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ENTRIES - 1);

  // action codes
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_PROBE  = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;
  localparam logic [1:0] ACT_INVAL  = 2'd3;

  // invalidate scope codes
  localparam logic [1:0] SCOPE_ALL     = 2'd0;
  localparam logic [1:0] SCOPE_VA_ASID = 2'd1;
  localparam logic [1:0] SCOPE_ASID    = 2'd2;
  localparam logic [1:0] SCOPE_VA      = 2'd3;

  localparam logic [63:0] ISSUE_ADDR_ASID = 64'hffff_0fff_ffff_ffff;
  localparam logic [63:0] ISSUE_ASID      = 64'hffff_0000_0000_0000;
  localparam logic [63:0] ISSUE_ADDR      = 64'h0000_0fff_ffff_ffff;
  localparam logic [63:0] MASK48          = 64'h0000_ffff_ffff_ffff;

  localparam logic [BB_W-1:0] BB_MIN    = 6'd12;
  localparam logic [BB_W-1:0] BB_MAX    = 6'd32;
  // last-level invalidate keeps keys whose shift field is above this
  localparam logic [BB_W-1:0] LL_MAX_SH = 6'd15;

  typedef struct packed {
    logic       inv;
    logic       last_level;
    logic [1:0] scope;
  } match_ctrl_t;

endpackage

// ----- hdl/tlb_mru_lookup_insert_invalidate.sv -----
// Top level of the fully associative translation buffer, recency ordered.
// Depends on tlb_pkg, tlb_match and tlb_ram.
//
// One request channel (in_valid / in_stall) carries an action with its
// operands; one result channel (out_valid / out_stall) returns exactly one
// result per request, in order. A request is taken only while the sequencer
// is idle; in_stall is high for the rest of its processing.
// Keys sit in flip-flops in recency order and are scanned one position per
// cycle through a single compare unit; entry data lives in a 32-entry RAM.
// Path of each request through the sequencer:
//   lookup hit: S_SCAN up to the hit position, S_MOVE, S_DONE
//   lookup miss: S_SCAN over all ENTRIES keys, S_DONE
//   insert: S_INS, S_DONE
//   invalidate: S_SCAN over all ENTRIES keys, S_DONE; straight to S_DONE on a fault
// A new request may be taken while a result still waits at the output; the
// next result is then held until the receiver drops out_stall.
// Reset is synchronous: all keys clear to the never-matching zero key and the
// recency order returns to identity. Entry data needs no clearing, since only
// keys written by an insert can hit.
module tlb_mru_lookup_insert_invalidate (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 action,
  input  logic [63:0]                vaddr,
  input  logic [15:0]                asid,
  input  logic [tlb_pkg::PA_W-1:0]   entry_pa,
  input  logic [tlb_pkg::BB_W-1:0]   entry_block_bits,
  input  logic                       entry_not_global,
  input  logic [tlb_pkg::ATTR_W-1:0] entry_attributes,
  input  logic                       inv_last_level_only,
  input  logic [1:0]                 inv_scope,
  input  logic [63:0]                operand_unknown_bits,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit,
  output logic [tlb_pkg::PA_W-1:0]   phys_addr,
  output logic [tlb_pkg::ATTR_W-1:0] attr_out,
  output logic [tlb_pkg::BB_W-1:0]   block_bits_out,
  output logic                       operand_fault
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;

  logic [tlb_pkg::KEY_W-1:0] tag_keys   [tlb_pkg::ENTRIES];
  logic [tlb_pkg::IDX_W-1:0] slot_order [tlb_pkg::ENTRIES];

  // latched request
  logic [1:0]                 req_action;
  logic [63:0]                req_vaddr;
  logic [15:0]                req_asid;
  logic [tlb_pkg::KEY_W-1:0]  req_vakey;
  logic [tlb_pkg::PA_W-1:0]   req_pa;
  logic [tlb_pkg::BB_W-1:0]   req_bb;
  logic                       req_global;
  logic [tlb_pkg::ATTR_W-1:0] req_attr;
  tlb_pkg::match_ctrl_t       req_ctrl;

  logic [tlb_pkg::IDX_W-1:0] idx;
  logic [tlb_pkg::IDX_W-1:0] hit_pos;
  logic [tlb_pkg::KEY_W-1:0] hit_key;
  logic [tlb_pkg::IDX_W-1:0] slot;
  logic                      res_hit;
  logic                      res_fault;

  logic [63:0]                issue;
  logic                       fault_in;
  logic [tlb_pkg::KEY_W-1:0]  vakey_in;
  logic [tlb_pkg::BB_W-1:0]   bb_sat;
  logic [tlb_pkg::KEY_W-1:0]  key_cur;
  logic                       match;
  logic [tlb_pkg::KEY_W-1:0]  ins_key;
  logic [tlb_pkg::ENTRY_W-1:0] rdata;
  logic [tlb_pkg::PA_W-1:0]   ent_pa;
  logic [tlb_pkg::BB_W-1:0]   ent_bb;
  logic [tlb_pkg::ATTR_W-1:0] ent_attr;
  logic [tlb_pkg::PA_W-1:0]   lo;
  logic [tlb_pkg::PA_W-1:0]   merged_pa;
  logic                       out_free;
  logic                       is_lookup;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign is_lookup = (req_action == tlb_pkg::ACT_LOOKUP) ||
                     (req_action == tlb_pkg::ACT_PROBE);

  always_comb begin
    unique case (inv_scope)
      tlb_pkg::SCOPE_ALL:     issue = '0;
      tlb_pkg::SCOPE_VA_ASID: issue = tlb_pkg::ISSUE_ADDR_ASID;
      tlb_pkg::SCOPE_ASID:    issue = tlb_pkg::ISSUE_ASID;
      tlb_pkg::SCOPE_VA:      issue = tlb_pkg::ISSUE_ADDR;
      default:                issue = '0;
    endcase
  end

  assign fault_in = (action == tlb_pkg::ACT_INVAL) && ((operand_unknown_bits & issue) != '0);

  // lookup key holds VA bits 48..2; invalidate operand holds VA bits 48..12 in 36..0
  assign vakey_in = (action == tlb_pkg::ACT_INVAL) ?
                    {vaddr[63:48], vaddr[36:0], 10'b0, 1'b1} :
                    {asid, vaddr[48:2], 1'b1};

  always_comb begin
    priority if (entry_block_bits < tlb_pkg::BB_MIN) begin
      bb_sat = tlb_pkg::BB_MIN;
    end else if (entry_block_bits > tlb_pkg::BB_MAX) begin
      bb_sat = tlb_pkg::BB_MAX;
    end else begin
      bb_sat = entry_block_bits;
    end
  end

  assign ins_key = {req_asid, req_vaddr[48:12], 4'b0, req_global,
                    req_bb - tlb_pkg::BB_W'(1)};

  assign key_cur = tag_keys[idx];

  tlb_match u_match (
    .key   (key_cur),
    .vakey (req_vakey),
    .ctrl  (req_ctrl),
    .match (match)
  );

  tlb_ram #(
    .WIDTH (tlb_pkg::ENTRY_W),
    .DEPTH (tlb_pkg::ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (state == S_INS),
    .waddr (slot_order[tlb_pkg::LAST_POS]),
    .wdata ({req_pa, req_bb, req_attr}),
    .raddr (slot),
    .rdata (rdata)
  );

  assign ent_pa    = rdata[tlb_pkg::ENTRY_W-1 -: tlb_pkg::PA_W];
  assign ent_bb    = rdata[tlb_pkg::ATTR_W +: tlb_pkg::BB_W];
  assign ent_attr  = rdata[tlb_pkg::ATTR_W-1:0];
  assign lo        = (tlb_pkg::PA_W'(1) << ent_bb) - tlb_pkg::PA_W'(1);
  assign merged_pa = (ent_pa & ~lo) | (req_vaddr[tlb_pkg::PA_W-1:0] & lo);

  // sequencer, request latch and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      res_hit   <= 1'b0;
      res_fault <= 1'b0;
    end else begin
      // a result loaded in S_DONE replaces the one leaving this cycle
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_action          <= action;
            req_vaddr           <= vaddr;
            req_asid            <= asid;
            req_vakey           <= vakey_in;
            req_pa              <= entry_pa;
            req_bb              <= bb_sat;
            req_global          <= !entry_not_global;
            req_attr            <= entry_attributes;
            req_ctrl.inv        <= (action == tlb_pkg::ACT_INVAL);
            req_ctrl.last_level <= inv_last_level_only;
            req_ctrl.scope      <= inv_scope;
            idx                 <= '0;
            res_hit             <= 1'b0;
            res_fault           <= fault_in;
            priority if (action == tlb_pkg::ACT_INSERT) begin
              state <= S_INS;
            end else if (fault_in) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (is_lookup && match) begin
            hit_pos <= idx;
            hit_key <= key_cur;
            slot    <= slot_order[idx];
            res_hit <= 1'b1;
            state   <= S_MOVE;
          end else if (idx == tlb_pkg::LAST_POS) begin
            state <= S_DONE;
          end else begin
            idx <= idx + tlb_pkg::IDX_W'(1);
          end
        end
        S_MOVE: begin
          state <= S_DONE;
        end
        S_INS: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            hit            <= res_hit;
            phys_addr      <= res_hit ? merged_pa : '0;
            attr_out       <= res_hit ? ent_attr : '0;
            block_bits_out <= res_hit ? ent_bb : '0;
            operand_fault  <= res_fault;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // key and recency arrays
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
        tag_keys[i]   <= '0;
        slot_order[i] <= tlb_pkg::IDX_W'(i);
      end
    end else begin
      unique case (state)
        S_SCAN: begin
          if (!is_lookup && match) begin
            tag_keys[idx] <= '0;
          end
        end
        S_MOVE: begin
          // for a lookup (not a probe), bring the hit to the front, sliding the more recent ones back
          if (req_action == tlb_pkg::ACT_LOOKUP) begin
            for (int i = 1; i < tlb_pkg::ENTRIES; i++) begin
              if (tlb_pkg::IDX_W'(i) <= hit_pos) begin
                tag_keys[i]   <= tag_keys[i-1];
                slot_order[i] <= slot_order[i-1];
              end
            end
            tag_keys[0]   <= hit_key;
            slot_order[0] <= slot;
          end
        end
        S_INS: begin
          for (int i = 1; i < tlb_pkg::ENTRIES; i++) begin
            tag_keys[i]   <= tag_keys[i-1];
            slot_order[i] <= slot_order[i-1];
          end
          tag_keys[0]   <= ins_key;
          slot_order[0] <= slot_order[tlb_pkg::LAST_POS];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/tlb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/tlb_match.sv -----
// Shared key compare unit: masked tag match for lookups and invalidates.
// Depends on tlb_pkg.
module tlb_match (
  input  logic [tlb_pkg::KEY_W-1:0] key,
  input  logic [tlb_pkg::KEY_W-1:0] vakey,
  input  tlb_pkg::match_ctrl_t      ctrl,
  output logic                      match
);

  logic [tlb_pkg::BB_W-1:0]  sh;
  logic [tlb_pkg::KEY_W-1:0] mask;
  logic                      drop_asid;
  logic                      addr_eq;
  logic                      asid_eq;

  assign sh = key[tlb_pkg::BB_W-1:0];

  always_comb begin
    // global keys ignore the asid; so does an invalidate by address in any asid
    drop_asid = key[6] | (ctrl.inv & (ctrl.scope == tlb_pkg::SCOPE_VA));
    mask = {tlb_pkg::KEY_W{1'b1}} << sh;
    if (drop_asid) begin
      mask = mask & tlb_pkg::MASK48;
    end
    addr_eq = (((vakey ^ key) & mask) == '0);
    asid_eq = (vakey[63:48] == key[63:48]);

    if (!ctrl.inv) begin
      match = addr_eq;
    end else if (ctrl.last_level && (sh > tlb_pkg::LL_MAX_SH)) begin
      match = 1'b0;
    end else begin
      unique case (ctrl.scope)
        tlb_pkg::SCOPE_ALL:     match = 1'b1;
        tlb_pkg::SCOPE_ASID:    match = asid_eq;
        tlb_pkg::SCOPE_VA_ASID: match = addr_eq;
        tlb_pkg::SCOPE_VA:      match = addr_eq;
        default:                match = 1'b0;
      endcase
    end
  end

endmodule

// ----- tb/tlb_mru_lookup_insert_invalidate_tb.sv -----
// Self-checking testbench for the recency-ordered translation buffer.
// Depends on tlb_pkg and the tlb_mru_lookup_insert_invalidate RTL.
`timescale 1ns / 1ps

module tlb_mru_lookup_insert_invalidate_tb;

  localparam int POOL = 16;

  typedef struct packed {
    logic [1:0]                 action;
    logic [63:0]                vaddr;
    logic [15:0]                asid;
    logic [tlb_pkg::PA_W-1:0]   entry_pa;
    logic [tlb_pkg::BB_W-1:0]   entry_block_bits;
    logic                       entry_not_global;
    logic [tlb_pkg::ATTR_W-1:0] entry_attributes;
    logic                       inv_last_level_only;
    logic [1:0]                 inv_scope;
    logic [63:0]                operand_unknown_bits;
  } xlat_req_t;

  typedef struct packed {
    logic                       hit;
    logic [tlb_pkg::PA_W-1:0]   phys_addr;
    logic [tlb_pkg::ATTR_W-1:0] attr_out;
    logic [tlb_pkg::BB_W-1:0]   block_bits_out;
    logic                       operand_fault;
  } xlat_rsp_t;

  localparam int REQ_W = $bits(xlat_req_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [63:0] vaddr = '0;
  logic [15:0] asid = '0;
  logic [tlb_pkg::PA_W-1:0] entry_pa = '0;
  logic [tlb_pkg::BB_W-1:0] entry_block_bits = '0;
  logic entry_not_global = 1'b0;
  logic [tlb_pkg::ATTR_W-1:0] entry_attributes = '0;
  logic inv_last_level_only = 1'b0;
  logic [1:0] inv_scope = '0;
  logic [63:0] operand_unknown_bits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [tlb_pkg::PA_W-1:0] phys_addr;
  logic [tlb_pkg::ATTR_W-1:0] attr_out;
  logic [tlb_pkg::BB_W-1:0] block_bits_out;
  logic operand_fault;

  // predicted buffer contents, position 0 is most recent
  logic [63:0]                mru_key  [tlb_pkg::ENTRIES];
  logic [tlb_pkg::IDX_W-1:0]  mru_slot [tlb_pkg::ENTRIES];
  logic [tlb_pkg::PA_W-1:0]   slot_pa  [tlb_pkg::ENTRIES];
  logic [tlb_pkg::BB_W-1:0]   slot_bb  [tlb_pkg::ENTRIES];
  logic [tlb_pkg::ATTR_W-1:0] slot_attr[tlb_pkg::ENTRIES];

  xlat_req_t   stim_q[$];
  xlat_rsp_t   xlate_q[$];
  xlat_req_t   cur_req;
  int unsigned sent_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned n_items = 0;
  int unsigned send_idle_pct, recv_stall_pct;
  logic        failed = 1'b0;

  always #4 clk = ~clk;

  tlb_mru_lookup_insert_invalidate dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .vaddr(vaddr), .asid(asid),
    .entry_pa(entry_pa), .entry_block_bits(entry_block_bits),
    .entry_not_global(entry_not_global), .entry_attributes(entry_attributes),
    .inv_last_level_only(inv_last_level_only), .inv_scope(inv_scope),
    .operand_unknown_bits(operand_unknown_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .phys_addr(phys_addr), .attr_out(attr_out),
    .block_bits_out(block_bits_out), .operand_fault(operand_fault)
  );

  function automatic logic [63:0] key_mask(logic [63:0] key, logic drop_asid);
    logic [63:0] m;
    m = {64{1'b1}} << key[5:0];
    if (drop_asid) m &= tlb_pkg::MASK48;
    return m;
  endfunction

  function automatic logic [tlb_pkg::BB_W-1:0] clamp_bb(logic [tlb_pkg::BB_W-1:0] b);
    if (b < tlb_pkg::BB_MIN) return tlb_pkg::BB_MIN;
    if (b > tlb_pkg::BB_MAX) return tlb_pkg::BB_MAX;
    return b;
  endfunction

  task automatic translate_step(input xlat_req_t r, output xlat_rsp_t o);
    logic [63:0] probe, key, issue, lo;
    logic [tlb_pkg::BB_W-1:0] bb;
    logic [tlb_pkg::IDX_W-1:0] slot;
    logic skip, drop;
    int h;
    o = '0;
    case (r.action)
      tlb_pkg::ACT_LOOKUP, tlb_pkg::ACT_PROBE: begin
        probe = {r.asid, r.vaddr[48:1]} | 64'd1;
        h = -1;
        for (int i = 0; i < tlb_pkg::ENTRIES; i++)
          if (h < 0 && ((probe ^ mru_key[i]) & key_mask(mru_key[i], mru_key[i][6])) == '0)
            h = i;
        if (h >= 0) begin
          key  = mru_key[h];
          slot = mru_slot[h];
          if (r.action == tlb_pkg::ACT_LOOKUP) begin
            for (int i = h; i > 0; i--) begin
              mru_key[i]  = mru_key[i-1];
              mru_slot[i] = mru_slot[i-1];
            end
            mru_key[0]  = key;
            mru_slot[0] = slot;
          end
          lo = (64'd2 << key[5:0]) - 64'd1;
          o.hit = 1'b1;
          o.phys_addr = (slot_pa[slot] & ~lo[tlb_pkg::PA_W-1:0]) |
                        (r.vaddr[tlb_pkg::PA_W-1:0] & lo[tlb_pkg::PA_W-1:0]);
          o.attr_out = slot_attr[slot];
          o.block_bits_out = slot_bb[slot];
        end
      end
      tlb_pkg::ACT_INSERT: begin
        bb = clamp_bb(r.entry_block_bits);
        slot = mru_slot[tlb_pkg::ENTRIES-1];
        for (int i = tlb_pkg::ENTRIES - 1; i > 0; i--) begin
          mru_key[i]  = mru_key[i-1];
          mru_slot[i] = mru_slot[i-1];
        end
        mru_key[0]  = {r.asid, r.vaddr[48:12], 4'b0, ~r.entry_not_global, bb - 6'd1};
        mru_slot[0] = slot;
        slot_pa[slot]   = r.entry_pa;
        slot_bb[slot]   = bb;
        slot_attr[slot] = r.entry_attributes;
      end
      default: begin
        case (r.inv_scope)
          tlb_pkg::SCOPE_VA_ASID: issue = tlb_pkg::ISSUE_ADDR_ASID;
          tlb_pkg::SCOPE_ASID:    issue = tlb_pkg::ISSUE_ASID;
          tlb_pkg::SCOPE_VA:      issue = tlb_pkg::ISSUE_ADDR;
          default:                issue = '0;
        endcase
        if ((r.operand_unknown_bits & issue) != '0) begin
          o.operand_fault = 1'b1;
        end else begin
          probe = {r.vaddr[63:48], r.vaddr[36:0], 11'd1};
          for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
            key  = mru_key[i];
            skip = 1'b0;
            if (r.inv_last_level_only && key[5:0] > tlb_pkg::LL_MAX_SH) skip = 1'b1;
            if (r.inv_scope == tlb_pkg::SCOPE_ASID && probe[63:48] != key[63:48])
              skip = 1'b1;
            if (r.inv_scope == tlb_pkg::SCOPE_VA_ASID || r.inv_scope == tlb_pkg::SCOPE_VA)
            begin
              drop = (r.inv_scope == tlb_pkg::SCOPE_VA) || key[6];
              if (((probe ^ key) & key_mask(key, drop)) != '0) skip = 1'b1;
            end
            if (!skip) mru_key[i] = '0;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  function automatic xlat_req_t lookup_req(logic [1:0] act, logic [63:0] va, logic [15:0] id);
    xlat_req_t r;
    r = '0;
    r.action = act;
    r.vaddr = va;
    r.asid = id;
    return r;
  endfunction

  function automatic xlat_req_t insert_req(logic [63:0] va, logic [15:0] id,
                                           logic [tlb_pkg::PA_W-1:0] pa,
                                           logic [tlb_pkg::BB_W-1:0] bb,
                                           logic ng, logic [tlb_pkg::ATTR_W-1:0] at);
    xlat_req_t r;
    r = '0;
    r.action = tlb_pkg::ACT_INSERT;
    r.vaddr = va;
    r.asid = id;
    r.entry_pa = pa;
    r.entry_block_bits = bb;
    r.entry_not_global = ng;
    r.entry_attributes = at;
    return r;
  endfunction

  function automatic xlat_req_t inval_req(logic [1:0] sc, logic [63:0] op, logic ll,
                                          logic [63:0] unk);
    xlat_req_t r;
    r = '0;
    r.action = tlb_pkg::ACT_INVAL;
    r.vaddr = op;
    r.inv_scope = sc;
    r.inv_last_level_only = ll;
    r.operand_unknown_bits = unk;
    return r;
  endfunction

  // invalidate operand: asid on top, page number (VA 48..12) at the bottom
  function automatic logic [63:0] inv_op(logic [15:0] id, logic [63:0] va);
    return {id, 11'd0, va[48:12]};
  endfunction

  function automatic logic [tlb_pkg::BB_W-1:0] pick_bb();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 6'd12;
      5:             return 6'd16;
      6:             return 6'($urandom_range(12, 32));
      7:             return 6'd21;
      8:             return 6'($urandom_range(0, 63));
      default:       return 6'd32;
    endcase
  endfunction

  // idle phases cycle every 64 transfers
  always_comb begin
    case (taken_cnt[7:6])
      2'd0:    begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      2'd1:    begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2'd2:    begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
    endcase
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && taken_cnt != sent_cnt)) begin
      if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_req = stim_q.pop_front();
        sent_cnt++;
        in_valid <= 1'b1;
        {action, vaddr, asid, entry_pa, entry_block_bits, entry_not_global,
         entry_attributes, inv_last_level_only, inv_scope, operand_unknown_bits} <= cur_req;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // transfer monitor: predict on request, compare on result
  always @(posedge clk) begin
    xlat_req_t req;
    xlat_rsp_t want, got;
    if (rst) begin
      for (int i = 0; i < tlb_pkg::ENTRIES; i++) begin
        mru_key[i]  = '0;
        mru_slot[i] = tlb_pkg::IDX_W'(i);
      end
    end else begin
      if (in_valid && !in_stall) begin
        req = {action, vaddr, asid, entry_pa, entry_block_bits, entry_not_global,
               entry_attributes, inv_last_level_only, inv_scope, operand_unknown_bits};
        translate_step(req, want);
        xlate_q.push_back(want);
        taken_cnt++;
      end
      if (out_valid && !out_stall) begin
        got = {hit, phys_addr, attr_out, block_bits_out, operand_fault};
        if (xlate_q.size() == 0) begin
          $error("result transfer with nothing outstanding: %0h", got);
          failed = 1'b1;
        end else begin
          want = xlate_q.pop_front();
          check_field("hit", 64'(want.hit), 64'(got.hit));
          check_field("phys_addr", 64'(want.phys_addr), 64'(got.phys_addr));
          check_field("attr_out", 64'(want.attr_out), 64'(got.attr_out));
          check_field("block_bits_out", 64'(want.block_bits_out),
                      64'(got.block_bits_out));
          check_field("operand_fault", 64'(want.operand_fault), 64'(got.operand_fault));
        end
      end
    end
  end

  initial begin
    logic [63:0] pool_va  [POOL];
    logic [15:0] pool_asid[POOL];
    logic [tlb_pkg::BB_W-1:0] pool_bb[POOL];
    logic        pool_ng  [POOL];
    logic [63:0] va_a, va_b, va_d, lo, va, op;
    xlat_req_t   r;
    int          p, sel, k;

    va_a = 64'h0000_1234_5678_9000;
    va_b = {64{1'b1}};
    va_d = 64'h5555_aaaa_5555_aaaa;
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, 64'h0, 16'h0));   // empty buffer
    stim_q.push_back(insert_req(va_a, 16'h0042, 48'h0000_abcd_e000, 6'd12, 1'b1, 13'h1555));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, va_a | 64'h123, 16'h0042));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_PROBE, va_a | 64'hfff, 16'h0042));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, va_a, 16'h0043)); // wrong asid
    stim_q.push_back(insert_req(va_b, 16'hffff, {tlb_pkg::PA_W{1'b1}}, 6'd32, 1'b0,
                                13'h1fff));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, 64'h0001_ffff_0000_0000,
                                16'h0));                               // global
    stim_q.push_back(insert_req(64'h0, 16'h0, 48'h1000, 6'd0, 1'b1, 13'h0));  // clamps up
    stim_q.push_back(insert_req(va_d, 16'h0007, 48'h8000_0000_0000, 6'd63, 1'b1, 13'h0aaa));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, 64'h0fff, 16'h0));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, va_d ^ 64'hffe0_0000_8765_4321,
                                16'h0007));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, va_d ^ 64'h1_0000_0000, 16'h0007));
    // duplicate of an existing page, newest must win
    stim_q.push_back(insert_req(va_a, 16'h0042, 48'h0000_5555_5000, 6'd12, 1'b1, 13'h0));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, va_a, 16'h0042));
    stim_q.push_back(inval_req(tlb_pkg::SCOPE_VA_ASID, inv_op(16'h0042, va_a), 1'b0,
                               64'h8000_0000_0000_0000));
    stim_q.push_back(inval_req(tlb_pkg::SCOPE_ASID, inv_op(16'h0007, va_d), 1'b0,
                               64'h0001_0000_0000_0000));
    stim_q.push_back(inval_req(tlb_pkg::SCOPE_VA, inv_op(16'h0, 64'h0), 1'b0, 64'h1));
    // unknown bits outside the used range must not fault
    stim_q.push_back(inval_req(tlb_pkg::SCOPE_VA_ASID, inv_op(16'h0042, va_a), 1'b0,
                               64'h0000_f000_0000_0000));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, va_a, 16'h0042));
    stim_q.push_back(inval_req(tlb_pkg::SCOPE_ALL, 64'h0, 1'b1, {64{1'b1}}));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, 64'h0, 16'h0));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, va_d, 16'h0007));
    stim_q.push_back(inval_req(tlb_pkg::SCOPE_ASID, inv_op(16'h0007, 64'h0), 1'b0, 64'h0));
    stim_q.push_back(inval_req(tlb_pkg::SCOPE_VA, inv_op(16'h1234, va_b), 1'b0, 64'h0));
    stim_q.push_back(lookup_req(tlb_pkg::ACT_LOOKUP, va_b, 16'hffff));
    stim_q.push_back(inval_req(tlb_pkg::SCOPE_ALL, 64'h0, 1'b0, 64'h0));

    for (int i = 0; i < POOL; i++) begin
      pool_va[i]   = {$urandom, $urandom};
      pool_asid[i] = 16'($urandom);
      pool_bb[i]   = pick_bb();
      pool_ng[i]   = ($urandom_range(0, 3) != 0);
    end

    // random part: mostly pool pages so lookups and invalidates find entries
    for (int n = 0; n < 500; n++) begin
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      p = $urandom_range(0, POOL - 1);
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 19) != 0) begin
        if (sel < 35 && $urandom_range(0, 4) == 0) begin
          pool_va[p]   = {$urandom, $urandom};
          pool_asid[p] = 16'($urandom);
          pool_bb[p]   = pick_bb();
          pool_ng[p]   = ($urandom_range(0, 3) != 0);
        end
        lo = (64'd1 << clamp_bb(pool_bb[p])) - 64'd1;
        va = (pool_va[p] & ~lo) | (r.vaddr & lo);
        if (sel < 35) begin
          r.action = tlb_pkg::ACT_INSERT;
          r.vaddr[48:0] = va[48:0];
          r.asid = pool_asid[p];
          r.entry_block_bits = pool_bb[p];
          r.entry_not_global = pool_ng[p];
        end else if (sel < 85) begin
          r.action = (sel < 75) ? tlb_pkg::ACT_LOOKUP : tlb_pkg::ACT_PROBE;
          r.vaddr[48:0] = va[48:0];
          if (pool_ng[p] && $urandom_range(0, 7) != 0) r.asid = pool_asid[p];
        end else begin
          r.action = tlb_pkg::ACT_INVAL;
          k = $urandom_range(0, 9);
          r.inv_scope = (k == 0) ? tlb_pkg::SCOPE_ALL : (k < 4) ? tlb_pkg::SCOPE_VA_ASID :
                        (k < 7) ? tlb_pkg::SCOPE_ASID : tlb_pkg::SCOPE_VA;
          r.inv_last_level_only = ($urandom_range(0, 3) == 0);
          op = inv_op(pool_asid[p], pool_va[p]);
          op[47:37] = r.vaddr[47:37];
          r.vaddr = op;
          k = $urandom_range(0, 9);
          if (k < 7) r.operand_unknown_bits = '0;
          else if (k < 9) r.operand_unknown_bits = 64'd1 << $urandom_range(0, 63);
        end
      end
      stim_q.push_back(r);
    end
    n_items = stim_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_cnt < n_items) @(posedge clk);
    while (xlate_q.size() != 0) @(posedge clk);
    repeat (tlb_pkg::ENTRIES + 8) @(posedge clk);
    if (!failed && xlate_q.size() == 0) begin
      $display("PASS tlb_mru_lookup_insert_invalidate");
    end else begin
      $display("FAIL tlb_mru_lookup_insert_invalidate");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL tlb_mru_lookup_insert_invalidate");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tlb_pkg.sv
hdl/tlb_ram.sv
hdl/tlb_match.sv
hdl/tlb_mru_lookup_insert_invalidate.sv
tb/tlb_mru_lookup_insert_invalidate_tb.sv
